FILE: design/fsp_pkg.sv
// shared types, character codes and helpers for the format specification parser
package fsp_pkg;

	// parse phase
	typedef enum logic [3:0] {
		PH_IDLE  = 4'd0,
		PH_FLAGS = 4'd1,
		PH_WDIG  = 4'd2,
		PH_WDONE = 4'd3,
		PH_DOT   = 4'd4,
		PH_PDIG  = 4'd5,
		PH_PDONE = 4'd6,
		PH_LEN   = 4'd7
	} fsp_phase_t;

	// conversion codes
	typedef enum logic [3:0] {
		CONV_C       = 4'd0,
		CONV_S       = 4'd1,
		CONV_D       = 4'd2,
		CONV_U       = 4'd3,
		CONV_X_LOW   = 4'd4,
		CONV_X_UP    = 4'd5,
		CONV_P       = 4'd6,
		CONV_N       = 4'd7,
		CONV_PERCENT = 4'd8,
		CONV_UNKNOWN = 4'd9
	} fsp_conv_t;

	// length modifier codes
	localparam logic [2:0] LEN_NONE = 3'd0;
	localparam logic [2:0] LEN_H    = 3'd1;
	localparam logic [2:0] LEN_HH   = 3'd2;
	localparam logic [2:0] LEN_L    = 3'd3;
	localparam logic [2:0] LEN_LL   = 3'd4;

	// flag bit positions
	localparam int FLAG_DASH  = 0;
	localparam int FLAG_ZERO  = 1;
	localparam int FLAG_SPACE = 2;
	localparam int FLAG_PLUS  = 3;
	localparam int FLAG_HASH  = 4;

	// characters
	localparam logic [7:0] CH_DASH    = 8'h2D;
	localparam logic [7:0] CH_ZERO    = 8'h30;
	localparam logic [7:0] CH_NINE    = 8'h39;
	localparam logic [7:0] CH_SPACE   = 8'h20;
	localparam logic [7:0] CH_PLUS    = 8'h2B;
	localparam logic [7:0] CH_HASH    = 8'h23;
	localparam logic [7:0] CH_STAR    = 8'h2A;
	localparam logic [7:0] CH_DOT     = 8'h2E;
	localparam logic [7:0] CH_PERCENT = 8'h25;
	localparam logic [7:0] CH_H       = 8'h68;
	localparam logic [7:0] CH_L       = 8'h6C;
	localparam logic [7:0] CH_C       = 8'h63;
	localparam logic [7:0] CH_S       = 8'h73;
	localparam logic [7:0] CH_D       = 8'h64;
	localparam logic [7:0] CH_I       = 8'h69;
	localparam logic [7:0] CH_U       = 8'h75;
	localparam logic [7:0] CH_XL      = 8'h78;
	localparam logic [7:0] CH_XU      = 8'h58;
	localparam logic [7:0] CH_P       = 8'h70;
	localparam logic [7:0] CH_N       = 8'h6E;

	localparam logic [30:0] SAT31 = 31'h7FFF_FFFF;

	// one decoded record
	typedef struct packed {
		logic [2:0]  length_kind;
		logic        prec_given;
		logic [31:0] prec_value;
		logic [30:0] field_width;
		logic [4:0]  flags;
		fsp_conv_t   conversion;
	} fsp_result_t;

	// acc * 10 + d, saturating at the 31-bit maximum
	function automatic logic [30:0] acc_digit(input logic [30:0] acc, input logic [3:0] d);
		logic [34:0] v;
		v = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0} + {31'd0, d};
		return (v > {4'd0, SAT31}) ? SAT31 : v[30:0];
	endfunction

	// conversion letter decode
	function automatic fsp_conv_t conv_code(input logic [7:0] c);
		fsp_conv_t r;
		unique case (c)
			CH_C:       r = CONV_C;
			CH_S:       r = CONV_S;
			CH_D, CH_I: r = CONV_D;
			CH_U:       r = CONV_U;
			CH_XL:      r = CONV_X_LOW;
			CH_XU:      r = CONV_X_UP;
			CH_P:       r = CONV_P;
			CH_N:       r = CONV_N;
			CH_PERCENT: r = CONV_PERCENT;
			default:    r = CONV_UNKNOWN;
		endcase
		return r;
	endfunction

endpackage

FILE: design/fsp_core.sv
// parser state registers and the per-character decode step
module fsp_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                step,
	input  logic [7:0]          char_in,
	input  logic [31:0]         star_arg,
	output logic                emit,
	output fsp_pkg::fsp_result_t result
);
	import fsp_pkg::*;

	fsp_phase_t  phase_q, phase_d;
	logic [4:0]  flags_q, flags_d;
	logic [30:0] width_q, width_d;
	logic [31:0] prec_q, prec_d;
	logic        pflag_q, pflag_d;
	logic [2:0]  len_q, len_d;
	logic        pend_q, pend_d;

	logic        digit;
	logic        lenc;
	logic [3:0]  dval;
	logic        tail;
	logic        lenstart;
	logic [31:0] neg_arg;

	assign digit   = (char_in >= CH_ZERO) && (char_in <= CH_NINE);
	assign lenc    = (char_in == CH_H) || (char_in == CH_L);
	assign dval    = char_in[3:0];
	assign neg_arg = ~star_arg + 32'd1;

	// record is built from the state before this character
	always_comb begin
		result.conversion  = conv_code(char_in);
		result.flags       = flags_q;
		result.field_width = width_q;
		result.prec_value  = prec_q;
		result.prec_given  = pflag_q;
		result.length_kind = len_q;
	end

	// next state
	always_comb begin
		phase_d  = phase_q;
		flags_d  = flags_q;
		width_d  = width_q;
		prec_d   = prec_q;
		pflag_d  = pflag_q;
		len_d    = len_q;
		pend_d   = pend_q;
		emit     = 1'b0;
		tail     = 1'b0;
		lenstart = 1'b0;
		unique case (phase_q)
			PH_FLAGS: begin
				if (char_in == CH_DASH) begin
					flags_d[FLAG_DASH] = 1'b1;
				end else if (char_in == CH_ZERO) begin
					flags_d[FLAG_ZERO] = 1'b1;
				end else if (char_in == CH_SPACE) begin
					flags_d[FLAG_SPACE] = 1'b1;
				end else if (char_in == CH_PLUS) begin
					flags_d[FLAG_PLUS] = 1'b1;
				end else if (char_in == CH_HASH) begin
					flags_d[FLAG_HASH] = 1'b1;
				end else if (digit) begin
					width_d = {27'd0, dval};
					phase_d = PH_WDIG;
				end else if (char_in == CH_STAR) begin
					if (star_arg[31]) begin
						flags_d[FLAG_DASH] = 1'b1;
						width_d = (star_arg == 32'h8000_0000) ? SAT31 : neg_arg[30:0];
					end else begin
						width_d = star_arg[30:0];
					end
					phase_d = PH_WDONE;
				end else begin
					tail = 1'b1;
				end
			end
			PH_WDIG: begin
				if (digit) begin
					width_d = acc_digit(width_q, dval);
				end else begin
					tail = 1'b1;
				end
			end
			PH_WDONE: begin
				tail = 1'b1;
			end
			PH_DOT: begin
				if (digit) begin
					prec_d  = {28'd0, dval};
					phase_d = PH_PDIG;
				end else if (char_in == CH_STAR) begin
					prec_d = star_arg;
					if (star_arg[31]) begin
						pflag_d = 1'b0;
					end
					phase_d = PH_PDONE;
				end else if (lenc) begin
					lenstart = 1'b1;
				end else begin
					emit = 1'b1;
				end
			end
			PH_PDIG: begin
				// precision digits never exceed 31 bits
				if (digit) begin
					prec_d = {1'b0, acc_digit(prec_q[30:0], dval)};
				end else if (lenc) begin
					lenstart = 1'b1;
				end else begin
					emit = 1'b1;
				end
			end
			PH_PDONE: begin
				if (lenc) begin
					lenstart = 1'b1;
				end else begin
					emit = 1'b1;
				end
			end
			PH_LEN: begin
				if (pend_q && (((char_in == CH_H) && (len_q == LEN_H)) ||
						((char_in == CH_L) && (len_q == LEN_L)))) begin
					len_d  = (len_q == LEN_H) ? LEN_HH : LEN_LL;
					pend_d = 1'b0;
				end else begin
					emit = 1'b1;
				end
			end
			default: begin
				// idle and unused codes wait for a percent sign
				if (char_in == CH_PERCENT) begin
					phase_d = PH_FLAGS;
					flags_d = '0;
					width_d = '0;
					prec_d  = '0;
					pflag_d = 1'b0;
					len_d   = LEN_NONE;
					pend_d  = 1'b0;
				end
			end
		endcase

		// shared handling after flags and width
		if (tail) begin
			if (char_in == CH_DOT) begin
				pflag_d = 1'b1;
				prec_d  = '0;
				phase_d = PH_DOT;
			end else if (lenc) begin
				lenstart = 1'b1;
			end else begin
				emit = 1'b1;
			end
		end

		// length letter opens the length phase
		if (lenstart) begin
			len_d   = (char_in == CH_H) ? LEN_H : LEN_L;
			pend_d  = 1'b1;
			phase_d = PH_LEN;
		end

		// conversion character returns everything to reset values
		if (emit) begin
			phase_d = PH_IDLE;
			flags_d = '0;
			width_d = '0;
			prec_d  = '0;
			pflag_d = 1'b0;
			len_d   = LEN_NONE;
			pend_d  = 1'b0;
		end
	end

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			flags_q <= '0;
			width_q <= '0;
			prec_q  <= '0;
			pflag_q <= 1'b0;
			len_q   <= LEN_NONE;
			pend_q  <= 1'b0;
		end else if (step) begin
			phase_q <= phase_d;
			flags_q <= flags_d;
			width_q <= width_d;
			prec_q  <= prec_d;
			pflag_q <= pflag_d;
			len_q   <= len_d;
			pend_q  <= pend_d;
		end
	end

endmodule

FILE: design/format_spec_parser.sv
// Format specification parser: one character per transaction, one record per conversion.
// Pipeline: a character is registered on input, decoded from the input register, and its
// record is captured in the output register; a stalled output register holds both stages.
// Throughput: one character per cycle while the output register is free or being drained.
// Reset: arst_n clears the parse state to idle and empties both registers at once.
module format_spec_parser (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,  // char_in[7:0], star_arg[39:8]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [79:0] m_tdata   // conversion[3:0], flag_dash[4], flag_zero[5], flag_space[6],
	                              // flag_plus[7], flag_hash[8], field_width[39:9],
	                              // prec_value[71:40], prec_given[72], length_kind[75:73], zero
);
	import fsp_pkg::*;

	logic        valid_s1;
	logic [7:0]  char_s1;
	logic [31:0] arg_s1;
	logic        advance;
	logic        emit;
	fsp_result_t result;
	fsp_result_t out_q;
	logic        out_valid_q;

	// the decode stage moves when the output register is free or being drained
	assign advance  = !out_valid_q || m_tready;
	assign s_tready = !valid_s1 || advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			char_s1 <= s_tdata[7:0];
			arg_s1  <= s_tdata[39:8];
		end
	end

	// parser core
	fsp_core u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.step     (valid_s1 && advance),
		.char_in  (char_s1),
		.star_arg (arg_s1),
		.emit     (emit),
		.result   (result)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1 && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1 && emit) begin
			out_q <= result;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {4'd0, out_q.length_kind, out_q.prec_given, out_q.prec_value,
		out_q.field_width, out_q.flags[FLAG_HASH], out_q.flags[FLAG_PLUS],
		out_q.flags[FLAG_SPACE], out_q.flags[FLAG_ZERO], out_q.flags[FLAG_DASH],
		out_q.conversion};

endmodule

FILE: tb/format_spec_parser_tb.sv
// testbench for the format specification parser: directed and random character streams
`timescale 1ns / 1ps

module format_spec_parser_tb;
	import fsp_pkg::*;

	localparam int CYCLE_LIMIT = 1_000_000;

	// one decoded conversion record as predicted
	typedef struct {
		fsp_conv_t   conv;
		logic [4:0]  flags;
		logic [30:0] width;
		logic [31:0] prec;
		logic        prec_on;
		logic [2:0]  len_kind;
	} spec_record_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [39:0] s_tdata;  // char_in[7:0], star_arg[39:8]
	logic        m_tvalid;
	logic        m_tready;
	logic [79:0] m_tdata;  // conversion[3:0], flag_dash[4], flag_zero[5], flag_space[6],
	                       // flag_plus[7], flag_hash[8], field_width[39:9],
	                       // prec_value[71:40], prec_given[72], length_kind[75:73], zero

	// predicted parser state
	fsp_phase_t  phase_q;
	logic [4:0]  flag_q;
	logic [30:0] width_q;
	logic [31:0] prec_q;
	logic        prec_on_q;
	logic [2:0]  len_q;
	logic        len_pend_q;

	spec_record_t expected_specs[$];
	int           mismatch_count;
	int           item_count;
	int           cycle_count;
	int           hold_request;
	bit           tx_gaps_on;
	bit           rx_gaps_on;

	logic [7:0] flag_set [5]  = '{CH_DASH, CH_ZERO, CH_SPACE, CH_PLUS, CH_HASH};
	logic [7:0] conv_set [10] = '{CH_C, CH_S, CH_D, CH_I, CH_U, CH_XL, CH_XU, CH_P, CH_N,
		CH_PERCENT};
	logic [7:0] noise_set [13] = '{CH_PERCENT, CH_DASH, CH_ZERO, CH_SPACE, CH_PLUS, CH_HASH,
		CH_STAR, CH_DOT, CH_H, CH_L, CH_NINE, CH_D, CH_XU};

	format_spec_parser uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	// clock
	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// run time guard
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("format_spec_parser_tb failed");
			$finish;
		end
	end

	// acc * 10 + d, clamped at the 31-bit maximum
	function automatic logic [31:0] scale_add_digit(input logic [31:0] acc, input logic [3:0] d);
		logic [35:0] v;
		v = 36'(acc) * 36'd10 + 36'(d);
		return (v > 36'h0_7FFF_FFFF) ? 32'h7FFF_FFFF : v[31:0];
	endfunction

	function automatic fsp_conv_t letter_to_conv(input logic [7:0] c);
		case (c)
			CH_C:       return CONV_C;
			CH_S:       return CONV_S;
			CH_D, CH_I: return CONV_D;
			CH_U:       return CONV_U;
			CH_XL:      return CONV_X_LOW;
			CH_XU:      return CONV_X_UP;
			CH_P:       return CONV_P;
			CH_N:       return CONV_N;
			CH_PERCENT: return CONV_PERCENT;
			default:    return CONV_UNKNOWN;
		endcase
	endfunction

	task automatic clear_spec();
		phase_q    = PH_IDLE;
		flag_q     = '0;
		width_q    = '0;
		prec_q     = '0;
		prec_on_q  = 1'b0;
		len_q      = LEN_NONE;
		len_pend_q = 1'b0;
	endtask

	task automatic emit_record(input logic [7:0] c);
		spec_record_t r;
		r.conv     = letter_to_conv(c);
		r.flags    = flag_q;
		r.width    = width_q;
		r.prec     = prec_q;
		r.prec_on  = prec_on_q;
		r.len_kind = len_q;
		expected_specs.push_back(r);
		clear_spec();
	endtask

	task automatic begin_length(input logic [7:0] c);
		len_q      = (c == CH_H) ? LEN_H : LEN_L;
		len_pend_q = 1'b1;
		phase_q    = PH_LEN;
	endtask

	// what may follow the width: dot, length letter, or the conversion
	task automatic after_width(input logic [7:0] c);
		if (c == CH_DOT) begin
			prec_on_q = 1'b1;
			prec_q    = '0;
			phase_q   = PH_DOT;
		end else if (c == CH_H || c == CH_L) begin
			begin_length(c);
		end else begin
			emit_record(c);
		end
	endtask

	// next-state predictor for one accepted character
	task automatic parse_char(input logic [7:0] c, input logic [31:0] arg);
		bit          digit;
		bit          len_letter;
		logic [3:0]  dval;
		logic [31:0] mag;
		digit      = (c >= CH_ZERO && c <= CH_NINE);
		len_letter = (c == CH_H || c == CH_L);
		dval       = 4'(c - CH_ZERO);
		case (phase_q)
			PH_FLAGS: begin
				if (c == CH_DASH) begin
					flag_q[FLAG_DASH] = 1'b1;
				end else if (c == CH_ZERO) begin
					flag_q[FLAG_ZERO] = 1'b1;
				end else if (c == CH_SPACE) begin
					flag_q[FLAG_SPACE] = 1'b1;
				end else if (c == CH_PLUS) begin
					flag_q[FLAG_PLUS] = 1'b1;
				end else if (c == CH_HASH) begin
					flag_q[FLAG_HASH] = 1'b1;
				end else if (digit) begin
					width_q = 31'(dval);
					phase_q = PH_WDIG;
				end else if (c == CH_STAR) begin
					// negative star width turns into left justify
					if (arg[31]) begin
						flag_q[FLAG_DASH] = 1'b1;
						mag     = ~arg + 32'd1;
						width_q = (arg == 32'h8000_0000) ? SAT31 : mag[30:0];
					end else begin
						width_q = arg[30:0];
					end
					phase_q = PH_WDONE;
				end else begin
					after_width(c);
				end
			end
			PH_WDIG: begin
				if (digit) begin
					mag     = scale_add_digit({1'b0, width_q}, dval);
					width_q = mag[30:0];
				end else begin
					after_width(c);
				end
			end
			PH_WDONE: after_width(c);
			PH_DOT: begin
				if (digit) begin
					prec_q  = 32'(dval);
					phase_q = PH_PDIG;
				end else if (c == CH_STAR) begin
					prec_q = arg;
					if (arg[31])
						prec_on_q = 1'b0;
					phase_q = PH_PDONE;
				end else if (len_letter) begin
					begin_length(c);
				end else begin
					emit_record(c);
				end
			end
			PH_PDIG: begin
				if (digit)
					prec_q = scale_add_digit(prec_q, dval);
				else if (len_letter)
					begin_length(c);
				else
					emit_record(c);
			end
			PH_PDONE: begin
				if (len_letter)
					begin_length(c);
				else
					emit_record(c);
			end
			PH_LEN: begin
				// only hh and ll may double
				if (len_pend_q && ((c == CH_H && len_q == LEN_H) ||
						(c == CH_L && len_q == LEN_L))) begin
					len_q      = len_q + 3'd1;
					len_pend_q = 1'b0;
				end else begin
					emit_record(c);
				end
			end
			default: begin
				if (c == CH_PERCENT) begin
					clear_spec();
					phase_q = PH_FLAGS;
				end
			end
		endcase
	endtask

	function automatic int idle_len(input bit enabled);
		int r;
		if (!enabled)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(4, 30);
	endfunction

	function automatic logic [31:0] rand_arg();
		case ($urandom_range(0, 9))
			0:       return 32'h8000_0000;
			1:       return 32'h7FFF_FFFF;
			2:       return 32'hFFFF_FFFF;
			3:       return 32'h0000_0000;
			4:       return 32'($urandom_range(0, 40));
			5:       return 32'(-$urandom_range(1, 40));
			default: return $urandom;
		endcase
	endfunction

	// one input transaction, predicted once accepted
	task automatic send_char(input logic [7:0] c, input logic [31:0] arg);
		int gap;
		gap = idle_len(tx_gaps_on);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {arg, c};
		do @(posedge clk); while (!s_tready);
		item_count++;
		parse_char(c, arg);
	endtask

	// string of characters; the first star takes star_a, any later one star_b
	task automatic send_text(input string s, input logic [31:0] star_a, input logic [31:0] star_b);
		int stars;
		logic [7:0] c;
		stars = 0;
		for (int i = 0; i < s.len(); i++) begin
			c = s[i];
			if (c == CH_STAR) begin
				send_char(c, (stars == 0) ? star_a : star_b);
				stars++;
			end else begin
				send_char(c, rand_arg());
			end
		end
	endtask

	task automatic send_digits(input bit first_nonzero);
		int n;
		n = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 3) : $urandom_range(9, 12);
		send_char(8'(CH_ZERO + (first_nonzero ? $urandom_range(1, 9) : $urandom_range(0, 9))),
			rand_arg());
		repeat (n - 1) send_char(8'(CH_ZERO + $urandom_range(0, 9)), rand_arg());
	endtask

	// specification with random content; the final character is occasionally a random byte
	task automatic send_spec();
		int sel;
		send_char(CH_PERCENT, rand_arg());
		if ($urandom_range(0, 9) >= 4)
			repeat ($urandom_range(1, 5)) send_char(flag_set[$urandom_range(0, 4)], rand_arg());
		sel = $urandom_range(0, 9);
		if (sel >= 8)
			send_char(CH_STAR, rand_arg());
		else if (sel >= 4)
			send_digits(1'b1);
		if ($urandom_range(0, 9) >= 5) begin
			send_char(CH_DOT, rand_arg());
			sel = $urandom_range(0, 3);
			if (sel == 3)
				send_char(CH_STAR, rand_arg());
			else if (sel >= 1)
				send_digits(1'b0);
		end
		case ($urandom_range(0, 9))
			5: send_char(CH_H, rand_arg());
			6: send_text("hh", 0, 0);
			7: send_char(CH_L, rand_arg());
			8: send_text("ll", 0, 0);
			default: ;
		endcase
		if ($urandom_range(0, 9) < 9)
			send_char(conv_set[$urandom_range(0, 9)], rand_arg());
		else
			send_char(8'($urandom_range(0, 255)), rand_arg());
	endtask

	// stray bytes that break sequences
	task automatic send_noise();
		repeat ($urandom_range(1, 8)) begin
			if ($urandom_range(0, 1))
				send_char(noise_set[$urandom_range(0, 12)], rand_arg());
			else
				send_char(8'($urandom_range(0, 255)), rand_arg());
		end
	endtask

	task automatic test_idle_bytes();
		send_char(8'h41, rand_arg());
		send_char(8'h00, rand_arg());
		send_char(8'hFF, rand_arg());
		send_text("%%", 0, 0);
	endtask

	task automatic test_flags_and_stars();
		send_text("%-0 +#*.*hhx", 32'h8000_0000, 32'hFFFF_FFFF);
		send_text("%*.*d", 32'h7FFF_FFFF, 32'h8000_0000);
		send_text("%.c", 0, 0);
	endtask

	task automatic test_digit_saturation();
		send_text("%3000000000.9999999999lln", 0, 0);
	endtask

	task automatic test_misplaced_bytes();
		send_text("%1*", 32'h0000_0005, 0);
		send_text("%..", 0, 0);
		send_text("%hhh", 0, 0);
		send_text("%hl", 0, 0);
		send_char(CH_PERCENT, rand_arg());
		send_char(8'h00, rand_arg());
	endtask

	// long receiver hold while the sender keeps pushing
	task automatic test_output_stall();
		tx_gaps_on   = 1'b0;
		hold_request = 250;
		repeat (20) send_text("%d", 0, 0);
		tx_gaps_on = 1'b1;
	endtask

	task automatic test_random_specs();
		int goal;
		int batch;
		goal  = item_count + 1650;
		batch = 0;
		while (item_count < goal) begin
			if (batch % 40 == 0) begin
				tx_gaps_on = ($urandom_range(0, 3) != 0);
				rx_gaps_on = ($urandom_range(0, 3) != 0);
			end
			batch++;
			if ($urandom_range(0, 99) < 85)
				send_spec();
			else
				send_noise();
		end
		tx_gaps_on = 1'b1;
		rx_gaps_on = 1'b1;
	endtask

	// receiver ready pattern: runs, random gaps, and requested holds
	initial begin
		int hold_left;
		int run_left;
		int idle_left;
		hold_left = 0;
		run_left  = 0;
		idle_left = 0;
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				m_tready <= 1'b0;
				hold_left--;
			end else if (hold_request > 0) begin
				m_tready     <= 1'b0;
				hold_left    = hold_request - 1;
				hold_request = 0;
			end else if (run_left > 0) begin
				m_tready <= 1'b1;
				run_left--;
			end else if (idle_left > 0) begin
				m_tready <= 1'b0;
				idle_left--;
			end else begin
				m_tready  <= 1'b1;
				run_left  = $urandom_range(0, 20);
				idle_left = idle_len(rx_gaps_on);
			end
		end
	end

	task automatic check_field(input string name, input logic [31:0] exp, input logic [31:0] act);
		if (exp !== act) begin
			$error("%s mismatch: expected 0x%0h, got 0x%0h", name, exp, act);
			mismatch_count++;
		end
	endtask

	// compare each output transaction with the oldest prediction
	always @(posedge clk) begin
		spec_record_t r;
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_specs.size() == 0) begin
				$error("record with no prediction pending: 0x%0h", m_tdata);
				mismatch_count++;
			end else begin
				r = expected_specs.pop_front();
				check_field("conversion", 32'(r.conv), 32'(m_tdata[3:0]));
				check_field("flag_dash", 32'(r.flags[FLAG_DASH]), 32'(m_tdata[4]));
				check_field("flag_zero", 32'(r.flags[FLAG_ZERO]), 32'(m_tdata[5]));
				check_field("flag_space", 32'(r.flags[FLAG_SPACE]), 32'(m_tdata[6]));
				check_field("flag_plus", 32'(r.flags[FLAG_PLUS]), 32'(m_tdata[7]));
				check_field("flag_hash", 32'(r.flags[FLAG_HASH]), 32'(m_tdata[8]));
				check_field("field_width", 32'(r.width), 32'(m_tdata[39:9]));
				check_field("prec_value", r.prec, m_tdata[71:40]);
				check_field("prec_given", 32'(r.prec_on), 32'(m_tdata[72]));
				check_field("length_kind", 32'(r.len_kind), 32'(m_tdata[75:73]));
			end
		end
	end

	// main sequence
	initial begin
		arst_n         = 1'b0;
		s_tvalid       = 1'b0;
		s_tdata        = '0;
		m_tready       = 1'b0;
		mismatch_count = 0;
		item_count     = 0;
		cycle_count    = 0;
		hold_request   = 0;
		tx_gaps_on     = 1'b1;
		rx_gaps_on     = 1'b1;
		clear_spec();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_idle_bytes();
		test_flags_and_stars();
		test_digit_saturation();
		test_misplaced_bytes();
		test_output_stall();
		test_random_specs();
		s_tvalid <= 1'b0;

		// drain outstanding records, then allow for the pipeline
		while (expected_specs.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		if (mismatch_count == 0 && expected_specs.size() == 0)
			$display("format_spec_parser_tb passed");
		else
			$display("format_spec_parser_tb failed");
		$finish;
	end

endmodule

FILE: sim.f
design/fsp_pkg.sv
design/fsp_core.sv
design/format_spec_parser.sv
tb/format_spec_parser_tb.sv
